// ===== hw/rtl/stdp_pkg.sv =====
// Shared constants for the STDP weight-update block.
package stdp_pkg;

  // Default table depth and time-difference width.
  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned TimeWidthDef    = 32;

  // Fixed field widths.
  localparam int unsigned EntryW  = 8;
  localparam int unsigned WeightW = 16;
  localparam int unsigned StampW  = 31;
  localparam int unsigned WinW    = 16;

  // Table entries are stored at this many fraction bits.
  localparam int unsigned EntryFrac = 8;

  // Reset values of the clamp and scale registers.
  localparam logic signed [WeightW-1:0] MaxWeightRst = 16'sh7FFF;
  localparam logic signed [WeightW-1:0] MinWeightRst = 16'sh8000;
  localparam logic [3:0]                ScaleRst     = 4'd8;

endpackage

// ===== hw/rtl/stdp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module stdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/stdp_weight_update.sv =====
// Top level of the STDP weight-update block: pipeline, table RAM and registers.
//
// Usage
//   Requests enter on start/busy: a request is taken at every rising edge with
//   start high and busy low. busy is always low, so a request may be issued in
//   every cycle. opcode 1 writes entry_value into the change table at
//   entry_index and yields no result; opcode 0 computes an updated weight from
//   the spike time stamps and old_weight.
//   Each update request yields one result on new_weight_o, in_window_o and
//   index_clamped_o, marked by valid_o for exactly one cycle once the request
//   has passed the clamp stage. Throughput is one request per cycle; the
//   five register stages (difference, window and index, table read, add,
//   clamp) each take a new request every cycle, with the table RAM read and
//   written at the same stage so results keep request order.
//   Registers are written over the APB port at byte address 4*i, by the user only
//   while no request is in flight (not enforced here); pready is always high.
//   Reset clears the pipeline and loads the register reset values. The change
//   table is not cleared and must be written before its entries are used.
//   The receiver cannot stall: results are shown once and not held.
module stdp_weight_update
  import stdp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned TIME_WIDTH    = TimeWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode_i,
  input  logic [StampW-1:0]         pre_time_i,
  input  logic [StampW-1:0]         post_time_i,
  input  logic signed [WeightW-1:0] old_weight_i,
  input  logic [EntryW-1:0]         entry_index_i,
  input  logic signed [EntryW-1:0]  entry_value_i,
  // result channel
  output logic                      valid_o,
  output logic signed [WeightW-1:0] new_weight_o,
  output logic                      in_window_o,
  output logic                      index_clamped_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW   = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;
  localparam int unsigned PW   = (AW > EntryW) ? AW : EntryW;
  localparam int unsigned SumW = WeightW + 2;

  localparam logic signed [CW:0] HalfIdx = (CW+1)'(TABLE_ENTRIES / 2);
  localparam logic signed [CW:0] TopIdx  = (CW+1)'(TABLE_ENTRIES - 1);
  localparam logic [PW:0]        DepthP  = (PW+1)'(TABLE_ENTRIES);

  // Register indexes
  localparam logic [2:0] RegLtdWin = 3'd0;
  localparam logic [2:0] RegLtpWin = 3'd1;
  localparam logic [2:0] RegResLog = 3'd2;
  localparam logic [2:0] RegMaxW   = 3'd3;
  localparam logic [2:0] RegMinW   = 3'd4;
  localparam logic [2:0] RegScale  = 3'd5;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [WinW-1:0]           ltd_window_q, ltp_window_q;
  logic [3:0]                resolution_log_q, scale_bits_q;
  logic signed [WeightW-1:0] upper_limit_q, lower_limit_q;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ltd_window_q     <= '0;
      ltp_window_q     <= '0;
      resolution_log_q <= '0;
      upper_limit_q    <= MaxWeightRst;
      lower_limit_q    <= MinWeightRst;
      scale_bits_q     <= ScaleRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegLtdWin: ltd_window_q     <= pwdata[WinW-1:0];
        RegLtpWin: ltp_window_q     <= pwdata[WinW-1:0];
        RegResLog: resolution_log_q <= pwdata[3:0];
        RegMaxW:   upper_limit_q    <= pwdata[WeightW-1:0];
        RegMinW:   lower_limit_q    <= pwdata[WeightW-1:0];
        RegScale:  scale_bits_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (cfg_idx)
      RegLtdWin: prdata = {16'd0, ltd_window_q};
      RegLtpWin: prdata = {16'd0, ltp_window_q};
      RegResLog: prdata = {28'd0, resolution_log_q};
      RegMaxW:   prdata = {{16{upper_limit_q[WeightW-1]}}, upper_limit_q};
      RegMinW:   prdata = {{16{lower_limit_q[WeightW-1]}}, lower_limit_q};
      RegScale:  prdata = {28'd0, scale_bits_q};
      default:   prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 0: time difference
  // ---------------------------------------------------------------------
  logic                        s0_valid_q;
  logic                        s0_op_q;
  logic signed [TIME_WIDTH-1:0] s0_diff_q;
  logic signed [WeightW-1:0]   s0_oldw_q;
  logic [EntryW-1:0]           s0_pos_q;
  logic signed [EntryW-1:0]    s0_val_q;
  logic [StampW:0]             diff_full;

  assign diff_full = {1'b0, post_time_i} - {1'b0, pre_time_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start & ~busy;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    s0_op_q   <= opcode_i;
    s0_diff_q <= diff_full[TIME_WIDTH-1:0];
    s0_oldw_q <= old_weight_i;
    s0_pos_q  <= entry_index_i;
    s0_val_q  <= entry_value_i;
  end

  // ---------------------------------------------------------------------
  // Stage 1: window check, table index and clamp
  // ---------------------------------------------------------------------
  logic signed [CW:0] d_ext, ltd_ext, ltp_ext, d_shr, idx_full;
  logic               win_d, clamp_d;
  logic [AW-1:0]      addr_d;
  logic [PW:0]        pos_ext;
  logic               wr_ok;

  assign d_ext    = {{(CW+1-TIME_WIDTH){s0_diff_q[TIME_WIDTH-1]}}, s0_diff_q};
  assign ltd_ext  = {{(CW+1-WinW){1'b0}}, ltd_window_q};
  assign ltp_ext  = {{(CW+1-WinW){1'b0}}, ltp_window_q};
  assign d_shr    = d_ext >>> resolution_log_q;
  assign idx_full = d_shr + HalfIdx;
  assign pos_ext  = (PW+1)'(s0_pos_q);
  assign wr_ok    = pos_ext < DepthP;

  // Pick the table address: write position or clamped lookup index
  always_comb begin
    win_d   = (d_ext >= -ltd_ext) && (d_ext <= ltp_ext);
    clamp_d = 1'b0;
    if (s0_op_q) begin
      addr_d = pos_ext[AW-1:0];
    end else if (idx_full < 0) begin
      addr_d  = '0;
      clamp_d = win_d;
    end else if (idx_full > TopIdx) begin
      addr_d  = TopIdx[AW-1:0];
      clamp_d = win_d;
    end else begin
      addr_d = idx_full[AW-1:0];
    end
  end

  logic                      s1_valid_q, s1_we_q;
  logic                      s1_win_q, s1_clamp_q, s1_neg_q;
  logic [AW-1:0]             s1_addr_q;
  logic signed [WeightW-1:0] s1_oldw_q;
  logic signed [EntryW-1:0]  s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_we_q    <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q & ~s0_op_q;
      s1_we_q    <= s0_valid_q & s0_op_q & wr_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_win_q   <= win_d;
    s1_clamp_q <= clamp_d;
    s1_neg_q   <= s0_diff_q[TIME_WIDTH-1];
    s1_addr_q  <= addr_d;
    s1_oldw_q  <= s0_oldw_q;
    s1_val_q   <= s0_val_q;
  end

  // ---------------------------------------------------------------------
  // Stage 2: change table access
  // ---------------------------------------------------------------------
  logic [EntryW-1:0] entry_rd;

  stdp_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (s1_we_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_val_q),
    .re_i    (s1_valid_q),
    .raddr_i (s1_addr_q),
    .rdata_o (entry_rd)
  );

  logic                      s2_valid_q, s2_win_q, s2_clamp_q, s2_neg_q;
  logic signed [WeightW-1:0] s2_oldw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_win_q   <= s1_win_q;
    s2_clamp_q <= s1_clamp_q;
    s2_neg_q   <= s1_neg_q;
    s2_oldw_q  <= s1_oldw_q;
  end

  // ---------------------------------------------------------------------
  // Stage 3: scale the entry and apply it
  // ---------------------------------------------------------------------
  logic [2:0]                scale_sh;
  logic signed [WeightW-1:0] change;
  logic signed [SumW-1:0]    oldw_ext, change_ext, sum_d;

  assign scale_sh   = (scale_bits_q > 4'(EntryFrac)) ?
                      3'(scale_bits_q - 4'(EntryFrac)) : 3'd0;
  assign change     = $signed({{(WeightW-EntryW){entry_rd[EntryW-1]}}, entry_rd})
                      <<< scale_sh;
  assign oldw_ext   = {{(SumW-WeightW){s2_oldw_q[WeightW-1]}}, s2_oldw_q};
  assign change_ext = {{(SumW-WeightW){change[WeightW-1]}}, change};

  // Subtract for depression, add for potentiation, pass through outside
  always_comb begin
    if (!s2_win_q) begin
      sum_d = oldw_ext;
    end else if (s2_neg_q) begin
      sum_d = oldw_ext - change_ext;
    end else begin
      sum_d = oldw_ext + change_ext;
    end
  end

  logic                   s3_valid_q, s3_win_q, s3_clamp_q;
  logic signed [SumW-1:0] s3_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_win_q   <= s2_win_q;
    s3_clamp_q <= s2_clamp_q;
    s3_sum_q   <= sum_d;
  end

  // ---------------------------------------------------------------------
  // Stage 4: clamp to max, then min, and present the result
  // ---------------------------------------------------------------------
  logic signed [SumW-1:0] max_ext, min_ext, upper, lower;

  assign max_ext = {{(SumW-WeightW){upper_limit_q[WeightW-1]}}, upper_limit_q};
  assign min_ext = {{(SumW-WeightW){lower_limit_q[WeightW-1]}}, lower_limit_q};

  always_comb begin
    upper = (s3_win_q && (s3_sum_q > max_ext)) ? max_ext : s3_sum_q;
    lower = (s3_win_q && (upper < min_ext)) ? min_ext : upper;
  end

  logic                      out_valid_q, out_win_q, out_clamp_q;
  logic signed [WeightW-1:0] out_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_win_q    <= s3_win_q;
    out_clamp_q  <= s3_clamp_q;
    out_weight_q <= lower[WeightW-1:0];
  end

  assign valid_o         = out_valid_q;
  assign new_weight_o    = out_weight_q;
  assign in_window_o     = out_win_q;
  assign index_clamped_o = out_clamp_q;

endmodule
